@@ hw/rtl/spl_pkg.sv @@
// Shared types, widths and codes for the sorted price level table.
`timescale 1ns / 1ps
`default_nettype none
package spl_pkg;

    localparam int KEY_W     = 20;
    localparam int PRICE_W   = 17;
    localparam int SIZE_W    = 40;
    localparam int DEPTH_DEF = 32;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PRICE_W-1:0] price;
        logic [SIZE_W-1:0]  size;
    } t_level;

    typedef logic [2:0] t_op;

    localparam t_op OP_HOLD   = 3'd0;
    localparam t_op OP_UPDATE = 3'd1;
    localparam t_op OP_CLEAR  = 3'd2;
    localparam t_op OP_ROT_L  = 3'd3;
    localparam t_op OP_ROT_R  = 3'd4;

    typedef struct packed {
        t_op  op;
        logic match_any;
        logic size_zero;
        logic can_insert;
    } t_cell_ctrl;

    localparam logic CFG_DESC   = 1'b0;
    localparam logic CFG_KEYPOS = 1'b1;

    localparam logic REQ_CLEAR = 1'b1;

endpackage
`default_nettype wire

@@ hw/rtl/spl_cell.sv @@
// One cell of the level chain: holds one level and trades it with its neighbours.
`timescale 1ns / 1ps
`default_nettype none
module spl_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire spl_pkg::t_cell_ctrl i_ctrl,
    input  wire spl_pkg::t_level    i_new,
    input  wire spl_pkg::t_level    i_left,
    input  wire logic               i_left_valid,
    input  wire logic               i_left_lt,
    input  wire spl_pkg::t_level    i_right,
    input  wire logic               i_right_valid,
    output spl_pkg::t_level         o_level,
    output logic                    o_valid,
    output logic                    o_lt,
    output logic                    o_match
);

    spl_pkg::t_level r_level;
    spl_pkg::t_level n_level;
    logic            r_valid;
    logic            n_valid;
    logic            w_lt;
    logic            w_match;

    assign w_lt    = r_valid && (r_level.key < i_new.key);
    assign w_match = r_valid && (r_level.key == i_new.key);

    always_comb begin
        n_valid = r_valid;
        n_level = r_level;
        unique case (i_ctrl.op)
            spl_pkg::OP_UPDATE: begin
                if (i_ctrl.match_any) begin
                    if (i_ctrl.size_zero) begin
                        if (!w_lt) begin
                            n_valid = i_right_valid;
                            n_level = i_right;
                        end
                    end else if (w_match) begin
                        n_level.price = i_new.price;
                        n_level.size  = i_new.size;
                    end
                end else if (!i_ctrl.size_zero && i_ctrl.can_insert && !w_lt) begin
                    if (i_left_lt) begin
                        n_valid = 1'b1;
                        n_level = i_new;
                    end else begin
                        n_valid = i_left_valid;
                        n_level = i_left;
                    end
                end
            end
            spl_pkg::OP_CLEAR: begin
                n_valid = 1'b0;
            end
            spl_pkg::OP_ROT_L: begin
                n_valid = i_right_valid;
                n_level = i_right;
            end
            spl_pkg::OP_ROT_R: begin
                n_valid = i_left_valid;
                n_level = i_left;
            end
            default: begin
                n_valid = r_valid;
                n_level = r_level;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_level <= n_level;
    end

    assign o_level = r_level;
    assign o_valid = r_valid;
    assign o_lt    = w_lt;
    assign o_match = w_match;

endmodule
`default_nettype wire

@@ hw/rtl/sorted_price_level_table.sv @@
// Top level of the sorted price level table: cell chain, readout sequencer and ports.
//
//   Channel  Direction  Handshake                   Word
//   in       input      i_in_valid / o_in_ready     one update or clear request
//   out      output     o_out_valid / i_out_ready   one price and size pair of the book
//   cfg      input      i_cfg_valid / o_cfg_ready   one register write
//
// On an update every cell compares and shifts in that same cycle.
// A readout rotates the whole chain once, emitting the valid levels from the end cell
// on the way; an empty book gives its single word.
// A stalled output word holds the rotation; no update is taken during a readout.
// Reset empties the chain and clears both registers and the overflow flag.
`timescale 1ns / 1ps
`default_nettype none
module sorted_price_level_table #(
    parameter int DEPTH = spl_pkg::DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_req_type,
    input  wire logic [spl_pkg::KEY_W-1:0]   i_level_key,
    input  wire logic [spl_pkg::PRICE_W-1:0] i_level_price,
    input  wire logic [spl_pkg::SIZE_W-1:0]  i_level_size,
    input  wire logic                        i_batch_last,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [spl_pkg::PRICE_W-1:0]      o_out_price,
    output logic [spl_pkg::SIZE_W-1:0]       o_out_size,
    output logic                             o_entry_valid,
    output logic                             o_run_last,
    output logic                             o_overflow_seen,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic                        i_cfg_index,
    input  wire logic                        i_cfg_data
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int STEP_W = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROT   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic [CNT_W-1:0]           r_emit;
    logic [STEP_W-1:0]          r_step;
    logic                       r_desc;
    logic                       r_keypos;
    logic                       r_ovf;
    logic                       r_ovf_lat;
    logic                       r_out_valid;
    logic [spl_pkg::PRICE_W-1:0] r_out_price;
    logic [spl_pkg::SIZE_W-1:0] r_out_size;
    logic                       r_out_entry;
    logic                       r_out_last;
    logic                       r_out_ovf;

    spl_pkg::t_level     w_new;
    spl_pkg::t_cell_ctrl w_ctrl;
    spl_pkg::t_level     w_level [DEPTH];
    logic [DEPTH-1:0]    w_valid;
    logic [DEPTH-1:0]    w_lt;
    logic [DEPTH-1:0]    w_match;

    logic w_in_acc;
    logic w_upd;
    logic w_clr;
    logic w_readout;
    logic w_match_any;
    logic w_size_zero;
    logic w_full;
    logic w_drop;
    logic w_ovf_next;
    logic w_slot_free;
    logic w_src_valid;
    logic w_step;
    spl_pkg::t_level w_src;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_clr       = w_in_acc && (i_req_type == spl_pkg::REQ_CLEAR);
    assign w_upd       = w_in_acc && (i_req_type != spl_pkg::REQ_CLEAR);
    assign w_readout   = w_clr || (w_upd && i_batch_last);

    assign w_new.key   = i_level_key;
    assign w_new.price = r_keypos ? i_level_price : i_level_key[spl_pkg::PRICE_W-1:0];
    assign w_new.size  = i_level_size;

    assign w_match_any = |w_match;
    assign w_size_zero = (i_level_size == '0);
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_drop      = w_upd && !w_match_any && !w_size_zero && w_full;
    assign w_ovf_next  = r_ovf || w_drop;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_src_valid = r_desc ? w_valid[DEPTH-1] : w_valid[0];
    assign w_src       = r_desc ? w_level[DEPTH-1] : w_level[0];
    assign w_step      = (r_state == ST_ROT) && (!w_src_valid || w_slot_free);

    always_comb begin
        w_ctrl.op         = spl_pkg::OP_HOLD;
        w_ctrl.match_any  = w_match_any;
        w_ctrl.size_zero  = w_size_zero;
        w_ctrl.can_insert = !w_full;
        if (w_upd) begin
            w_ctrl.op = spl_pkg::OP_UPDATE;
        end else if (w_clr) begin
            w_ctrl.op = spl_pkg::OP_CLEAR;
        end else if (w_step) begin
            w_ctrl.op = r_desc ? spl_pkg::OP_ROT_R : spl_pkg::OP_ROT_L;
        end
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        localparam int L = (k == 0) ? DEPTH - 1 : k - 1;
        localparam int R = (k == DEPTH - 1) ? 0 : k + 1;
        logic w_left_lt;
        logic w_right_valid;
        if (k == 0) begin : g_head
            assign w_left_lt = 1'b1;
        end else begin : g_body
            assign w_left_lt = w_lt[L];
        end
        if (k == DEPTH - 1) begin : g_tail
            assign w_right_valid = (r_state == ST_ROT) && w_valid[R];
        end else begin : g_inner
            assign w_right_valid = w_valid[R];
        end
        spl_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_new        (w_new),
            .i_left       (w_level[L]),
            .i_left_valid (w_valid[L]),
            .i_left_lt    (w_left_lt),
            .i_right      (w_level[R]),
            .i_right_valid(w_right_valid),
            .o_level      (w_level[k]),
            .o_valid      (w_valid[k]),
            .o_lt         (w_lt[k]),
            .o_match      (w_match[k])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_clr) begin
            n_count = '0;
        end else if (w_upd) begin
            if (w_match_any && w_size_zero) begin
                n_count = r_count - CNT_W'(1);
            end else if (!w_match_any && !w_size_zero && !w_full) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_readout) begin
                    n_state = (w_clr || (n_count == '0)) ? ST_EMPTY : ST_ROT;
                end
            end
            ST_ROT: begin
                if (w_step && (r_step == STEP_W'(DEPTH - 1))) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_emit      <= '0;
            r_step      <= '0;
            r_desc      <= 1'b0;
            r_keypos    <= 1'b0;
            r_ovf       <= 1'b0;
            r_ovf_lat   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    spl_pkg::CFG_DESC:   r_desc   <= i_cfg_data;
                    spl_pkg::CFG_KEYPOS: r_keypos <= i_cfg_data;
                endcase
            end
            if (w_readout) begin
                r_ovf_lat <= w_ovf_next;
                r_ovf     <= 1'b0;
                r_emit    <= '0;
                r_step    <= '0;
            end else begin
                r_ovf <= w_ovf_next;
                if (w_step) begin
                    r_step <= r_step + STEP_W'(1);
                    if (w_src_valid) begin
                        r_emit <= r_emit + CNT_W'(1);
                    end
                end
            end
            if ((w_step && w_src_valid) || ((r_state == ST_EMPTY) && w_slot_free)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_src_valid) begin
            r_out_price <= w_src.price;
            r_out_size  <= w_src.size;
            r_out_entry <= 1'b1;
            r_out_last  <= (r_emit == (r_count - CNT_W'(1)));
            r_out_ovf   <= r_ovf_lat;
        end else if ((r_state == ST_EMPTY) && w_slot_free) begin
            r_out_price <= '0;
            r_out_size  <= '0;
            r_out_entry <= 1'b0;
            r_out_last  <= 1'b1;
            r_out_ovf   <= r_ovf_lat;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_price     = r_out_price;
    assign o_out_size      = r_out_size;
    assign o_entry_valid   = r_out_entry;
    assign o_run_last      = r_out_last;
    assign o_overflow_seen = r_out_ovf;

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("level count exceeds the chain depth");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(w_valid) == int'(r_count)))
        else $error("occupied cells disagree with the level count");

    a_readout_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_readout |=> (r_state != ST_IDLE))
        else $error("readout request did not start a readout");

    a_empty_word_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_entry) |-> r_out_last)
        else $error("empty book word not marked as last");

endmodule
`default_nettype wire
